@@ src/reb_pkg.sv @@
// Shared types, constants and the quadrature table for the encoder and button event decoder.
package reb_pkg;

	localparam int TIMER_W = 16;
	localparam int CFG_W   = 16;
	localparam int CMP_W   = (TIMER_W > CFG_W) ? TIMER_W : CFG_W;

	typedef logic [CMP_W-1:0] cmp_t;

	// Register indexes of the write port
	localparam logic REG_LONG_PRESS = 1'b0;
	localparam logic REG_MIN_CLICK  = 1'b1;

	localparam logic [CFG_W-1:0] LONG_PRESS_RST = CFG_W'(800);
	localparam logic [CFG_W-1:0] MIN_CLICK_RST  = CFG_W'(20);

	localparam logic signed [15:0] CNT_MAX = 16'sh7FFF;
	localparam logic signed [15:0] CNT_MIN = 16'sh8000;
	localparam logic signed [4:0]  ACC_HI  = 5'sd7;
	localparam logic signed [4:0]  ACC_LO  = -5'sd8;
	localparam logic signed [4:0]  DETENT_STEPS = 5'sd2;
	localparam logic [1:0]         PINS_DETENT  = 2'b11;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_UP    = 3'd1,
		EV_DOWN  = 3'd2,
		EV_TAP   = 3'd3,
		EV_LONG  = 3'd4
	} event_t;

	// Index is {previous A, previous B, A, B}
	localparam logic signed [1:0] QUAD_DELTA [16] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

	typedef struct packed {
		logic [1:0]          prev_pins;
		logic signed [3:0]   step_acc;
		logic signed [15:0]  detent_cnt;
		logic                last_button;
		logic [TIMER_W-1:0]  press_timer;
		logic                long_reported;
	} state_t;

	typedef struct packed {
		logic [CFG_W-1:0] long_press_ticks;
		logic [CFG_W-1:0] min_click_ticks;
	} cfg_t;

endpackage

@@ src/reb_update.sv @@
// Next-state and event logic for one pin sample.
module reb_update (
	input  reb_pkg::state_t cur,
	input  reb_pkg::cfg_t   cfg,
	input  logic            enc_a,
	input  logic            enc_b,
	input  logic            button_level,
	output reb_pkg::state_t nxt,
	output reb_pkg::event_t ev
);
	import reb_pkg::*;

	logic [1:0]         pins;
	logic signed [1:0]  delta;
	logic signed [4:0]  acc_sum;
	logic signed [3:0]  acc_sat;
	logic signed [15:0] cnt_enc;
	logic [TIMER_W-1:0] timer_inc;

	assign pins  = {enc_a, enc_b};
	assign delta = QUAD_DELTA[{cur.prev_pins, pins}];
	assign acc_sum = {cur.step_acc[3], cur.step_acc} + {{3{delta[1]}}, delta};
	assign timer_inc = (cur.press_timer != '1) ? cur.press_timer + 1'b1 : cur.press_timer;

	always_comb begin
		if (acc_sum > ACC_HI) begin
			acc_sat = ACC_HI[3:0];
		end else if (acc_sum < ACC_LO) begin
			acc_sat = ACC_LO[3:0];
		end else begin
			acc_sat = acc_sum[3:0];
		end
	end

	// Detent position: fold the accumulator into the pending count
	always_comb begin
		cnt_enc = cur.detent_cnt;
		if (pins == PINS_DETENT) begin
			if (acc_sum >= DETENT_STEPS && cur.detent_cnt != CNT_MAX) begin
				cnt_enc = cur.detent_cnt + 16'sd1;
			end else if (acc_sum <= -DETENT_STEPS && cur.detent_cnt != CNT_MIN) begin
				cnt_enc = cur.detent_cnt - 16'sd1;
			end
		end
	end

	always_comb begin
		nxt               = cur;
		nxt.prev_pins     = pins;
		nxt.step_acc      = (pins == PINS_DETENT) ? 4'sd0 : acc_sat;
		nxt.detent_cnt    = cnt_enc;
		nxt.press_timer   = timer_inc;
		ev                = EV_NONE;
		if (cnt_enc > 16'sd0) begin
			nxt.detent_cnt = cnt_enc - 16'sd1;
			ev             = EV_UP;
		end else if (cnt_enc < 16'sd0) begin
			nxt.detent_cnt = cnt_enc + 16'sd1;
			ev             = EV_DOWN;
		end else begin
			// Press edge: restart the timer
			if (!button_level && cur.last_button) begin
				nxt.press_timer   = '0;
				nxt.long_reported = 1'b0;
			end
			if (!button_level && !nxt.long_reported &&
			    cmp_t'(nxt.press_timer) > cmp_t'(cfg.long_press_ticks)) begin
				nxt.long_reported = 1'b1;
				nxt.last_button   = 1'b0;
				ev                = EV_LONG;
			end else if (button_level && !cur.last_button) begin
				nxt.last_button = 1'b1;
				if (!nxt.long_reported &&
				    cmp_t'(nxt.press_timer) > cmp_t'(cfg.min_click_ticks)) begin
					ev = EV_TAP;
				end
			end else begin
				nxt.last_button = button_level;
			end
		end
	end

endmodule

@@ src/rotary_encoder_button_events_core.sv @@
// Top level of the rotary encoder and push button event decoder.
module rotary_encoder_button_events_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       enc_a,
	input  logic                       enc_b,
	input  logic                       button_level,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2:0]                 event_res,
	output logic signed [15:0]         pending_detents,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [reb_pkg::CFG_W-1:0]  wr_data
);
	// One beat in is one millisecond sample of pins A, B and the active-low
	// button; one beat out follows for each, carrying the event code and the
	// detents still pending. A sample can be taken every cycle unless the output
	// stalls. The sample is held in an input register, and the combinational
	// state update writes the result register. Rotation events are drained at
	// one detent per sample; the button is only looked at when none is pending.
	// Write long_press_ticks (index 0) and min_click_ticks (index 1) only while
	// no beat is in flight.
	import reb_pkg::*;

	logic    valid_s1, a_s1, b_s1, button_s1;
	logic    out_valid_q;
	event_t  event_q;
	logic signed [15:0] pending_q;
	state_t  state_q, state_nxt;
	cfg_t    cfg_q;
	event_t  ev_nxt;
	logic    advance, accept;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	reb_update u_update (
		.cur          (state_q),
		.cfg          (cfg_q),
		.enc_a        (a_s1),
		.enc_b        (b_s1),
		.button_level (button_s1),
		.nxt          (state_nxt),
		.ev           (ev_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks <= LONG_PRESS_RST;
			cfg_q.min_click_ticks  <= MIN_CLICK_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LONG_PRESS: cfg_q.long_press_ticks <= wr_data;
				REG_MIN_CLICK:  cfg_q.min_click_ticks  <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q.prev_pins     <= PINS_DETENT;
			state_q.step_acc      <= 4'sd0;
			state_q.detent_cnt    <= 16'sd0;
			state_q.last_button   <= 1'b1;
			state_q.press_timer   <= '0;
			state_q.long_reported <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_s1      <= enc_a;
			b_s1      <= enc_b;
			button_s1 <= button_level;
		end
		if (advance) begin
			event_q   <= ev_nxt;
			pending_q <= state_nxt.detent_cnt;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_res       = event_q;
	assign pending_detents = pending_q;

`ifndef ASSERT_OFF
	a_button_only_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_TAP || event_res == EV_LONG) |-> pending_detents == 16'sd0)
		else $error("button event reported while detents pending");

	a_up_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_UP |-> !pending_detents[15])
		else $error("up event left a negative pending count");

	a_down_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_DOWN |-> (pending_detents[15] || pending_detents == 16'sd0))
		else $error("down event left a positive pending count");

	a_acc_clear_at_detent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.prev_pins == PINS_DETENT |-> state_q.step_acc == 4'sd0)
		else $error("step accumulator not cleared at detent");

	a_long_holds_button: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q.long_reported) |-> !state_q.last_button)
		else $error("long press flagged with button released");
`endif

endmodule
